@@ sv/umjp_pkg.sv @@
package umjp_pkg;

    typedef enum logic [3:0] {
        PH_OPEN, PH_KEY_START, PH_KEY, PH_COLON, PH_NUM_START, PH_NUM,
        PH_STR_START, PH_STR, PH_HEX_START, PH_HEX, PH_AFTER, PH_DONE, PH_ERR
    } t_phase;

    typedef enum logic [3:0] {
        ST_OK = 4'd0, ST_SYNTAX = 4'd1, ST_UNKNOWN = 4'd2, ST_DUP = 4'd3,
        ST_NUMBER = 4'd4, ST_STRING = 4'd5, ST_HEX = 4'd6, ST_SEMANTIC = 4'd7,
        ST_LENGTH = 4'd8
    } t_status;

    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_NUMBER  = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    localparam logic [2:0] FID_SCHEMA      = 3'd0;
    localparam logic [2:0] FID_BUILD       = 3'd3;
    localparam logic [2:0] FID_BUILD_FLOOR = 3'd4;
    localparam logic [2:0] FID_SHA256      = 3'd6;

    localparam logic [7:0] HASH_DIGITS = 8'd64;
    localparam logic [7:0] SIGN_DIGITS = 8'd128;

    localparam int CFG_MAX_TEXT  = 0;
    localparam int CFG_MAX_IMAGE = 1;

    // key text, padded with zero; key_len gives length
    function automatic logic [7:0] key_char(input logic [2:0] k, input logic [3:0] p);
        logic [71:0] s;
        case (k)
            3'd0:    s = {"schema", 24'd0};
            3'd1:    s = {"product", 16'd0};
            3'd2:    s = {"version", 16'd0};
            3'd3:    s = {"build", 32'd0};
            3'd4:    s = {"min_", "build"};
            3'd5:    s = {"size", 40'd0};
            3'd6:    s = {"sha256", 24'd0};
            default: s = "signature";
        endcase
        if (p < 4'd9) key_char = s[8'd71 - {p, 3'd0} -: 8];
        else key_char = 8'd0;
    endfunction

    function automatic logic [3:0] key_len(input logic [2:0] k);
        case (k)
            3'd0:    key_len = 4'd6;
            3'd1:    key_len = 4'd7;
            3'd2:    key_len = 4'd7;
            3'd3:    key_len = 4'd5;
            3'd4:    key_len = 4'd9;
            3'd5:    key_len = 4'd4;
            3'd6:    key_len = 4'd6;
            default: key_len = 4'd9;
        endcase
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
    endfunction

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  field_id;
        logic [31:0] value;
        logic [5:0]  byte_index;
        logic [3:0]  status;
        logic        last;
    } t_result;

endpackage

@@ sv/umjp_if.sv @@
interface umjp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_text;
    modport source (output valid, output data_byte, output end_of_text, input ready);
    modport sink (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface umjp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  field_id;
    logic [31:0] value;
    logic [5:0]  byte_index;
    logic [3:0]  status;
    logic        last;
    modport source (output valid, output kind, output field_id, output value,
                    output byte_index, output status, output last, input ready);
    modport sink (input valid, input kind, input field_id, input value,
                  input byte_index, input status, input last, output ready);
endinterface

@@ sv/umjp_out_queue.sv @@
// Four-entry result queue; each parsed byte pushes up to two results.
module umjp_out_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_push_cnt,
    input  umjp_pkg::t_result   i_push0,
    input  umjp_pkg::t_result   i_push1,
    output logic                o_room,
    umjp_out_if.source          o_out
);
    umjp_pkg::t_result r_mem [4];
    logic [1:0] r_rd, r_wr;
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    logic       pop;

    assign pop   = o_out.valid && o_out.ready;
    assign n_cnt = r_cnt + {1'b0, i_push_cnt} - {2'b0, pop};
    // room for two more after this cycle's pop
    assign o_room = (r_cnt - {2'b0, pop}) <= 3'd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_wr  <= r_wr + i_push_cnt;
            if (pop) r_rd <= r_rd + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) r_mem[r_wr] <= i_push0;
        if (i_push_cnt == 2'd2) r_mem[r_wr + 2'd1] <= i_push1;
    end

    assign o_out.valid      = r_cnt != 3'd0;
    assign o_out.kind       = r_mem[r_rd].kind;
    assign o_out.field_id   = r_mem[r_rd].field_id;
    assign o_out.value      = r_mem[r_rd].value;
    assign o_out.byte_index = r_mem[r_rd].byte_index;
    assign o_out.status     = r_mem[r_rd].status;
    assign o_out.last       = r_mem[r_rd].last;

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4) else $error("queue overflow");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_cnt != 2'd0) |-> o_room) else $error("push without room");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_push_cnt == 2'd0 |=> r_cnt == $past(r_cnt) - 3'd1)
        else $error("count step");
`endif
endmodule

@@ sv/update_manifest_json_parser_unit.sv @@
// Manifest parser: one byte accepted per cycle while the result queue has room,
// results queued behind it. Latency: a byte's first result is presented the cycle
// after its transfer when the result queue is empty, later behind results still waiting.
// Throughput: one byte per cycle while the queue has room; each byte gives up to two
// results, drained one per cycle while the receiver is ready, so result stalls throttle input.
// Reset (synchronous, active low) clears parser state and sets registers to defaults.
module update_manifest_json_parser_unit #(
    parameter int KEY_CHARS  = 15,
    parameter int TEXT_CHARS = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    umjp_in_if.sink     i_in,
    umjp_out_if.source  o_out
);
    localparam logic [4:0] KEY_MAX  = 5'(KEY_CHARS);
    localparam logic [7:0] TEXT_MAX = 8'(TEXT_CHARS);

    logic [15:0] r_max_text;
    logic [31:0] r_max_image;

    umjp_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_key_match, n_key_match;
    logic [4:0]  r_key_pos, n_key_pos;
    logic [7:0]  r_seen, n_seen;
    logic [3:0]  r_fcnt, n_fcnt;
    logic [31:0] r_acc, n_acc;
    logic        r_lz, n_lz;
    logic [7:0]  r_slen, n_slen;
    logic [4:0]  r_hn, n_hn;
    logic [15:0] r_schema, n_schema;
    logic [31:0] r_build, n_build, r_minb, n_minb, r_size, n_size;
    logic [3:0]  r_err, n_err;
    logic [15:0] r_bcnt, n_bcnt;

    umjp_pkg::t_result res0, res1;
    logic [1:0] push_cnt;
    logic       room, take;

    logic [7:0] c;
    logic [2:0] fid;
    logic       is_dig, is_hex;
    logic [3:0] dig, hv;
    logic [35:0] acc10;
    logic [7:0] digits;
    logic [3:0] st;

    assign i_in.ready = room;
    assign take = i_in.valid && room;
    assign c = i_in.data_byte;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_text  <= 16'd1024;
            r_max_image <= 32'h00B0_0000;
        end else if (i_cfg_we) begin
            if (i_cfg_index == 1'(umjp_pkg::CFG_MAX_TEXT)) r_max_text <= i_cfg_data[15:0];
            else r_max_image <= i_cfg_data;
        end
    end

    // current field: lowest set match bit
    always_comb begin
        fid = 3'd0;
        for (int k = 7; k >= 0; k--) if (r_key_match[k]) fid = 3'(k);
    end

    assign is_dig = c >= "0" && c <= "9";
    assign dig    = c[3:0];
    assign acc10  = {4'd0, r_acc} * 36'd10 + {32'd0, dig};
    assign digits = (fid == umjp_pkg::FID_SHA256) ? umjp_pkg::HASH_DIGITS
                                                  : umjp_pkg::SIGN_DIGITS;
    always_comb begin
        is_hex = 1'b1;
        hv = 4'd0;
        if (is_dig) hv = dig;
        else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) hv = c[3:0] + 4'd9;
        else is_hex = 1'b0;
    end

    // parse one byte
    always_comb begin
        n_phase = r_phase; n_key_match = r_key_match; n_key_pos = r_key_pos;
        n_seen = r_seen; n_fcnt = r_fcnt; n_acc = r_acc; n_lz = r_lz;
        n_slen = r_slen; n_hn = r_hn; n_schema = r_schema; n_build = r_build;
        n_minb = r_minb; n_size = r_size; n_err = r_err; n_bcnt = r_bcnt;
        res0 = '0; res1 = '0; push_cnt = 2'd0; st = 4'd0;
        if (take) begin
            if (r_bcnt >= r_max_text) begin
                n_err = umjp_pkg::ST_LENGTH; n_phase = umjp_pkg::PH_ERR;
            end else n_bcnt = r_bcnt + 16'd1;
            case (r_phase)
                umjp_pkg::PH_OPEN: begin
                    if (c == "{") n_phase = umjp_pkg::PH_KEY_START;
                    else if (!umjp_pkg::is_space(c)) begin
                        n_err = umjp_pkg::ST_SYNTAX; n_phase = umjp_pkg::PH_ERR;
                    end
                end
                umjp_pkg::PH_KEY_START: begin
                    if (c == "\"") begin
                        n_phase = umjp_pkg::PH_KEY; n_key_match = 8'hFF; n_key_pos = '0;
                    end else if (!umjp_pkg::is_space(c)) begin
                        n_err = umjp_pkg::ST_SYNTAX; n_phase = umjp_pkg::PH_ERR;
                    end
                end
                umjp_pkg::PH_KEY: begin
                    if (c == "\"") begin
                        for (int k = 0; k < 8; k++)
                            if ({1'b0, umjp_pkg::key_len(3'(k))} != r_key_pos)
                                n_key_match[k] = 1'b0;
                        n_phase = umjp_pkg::PH_COLON;
                    end else if (c < 8'h20 || c == "\\" || r_key_pos >= KEY_MAX) begin
                        n_err = umjp_pkg::ST_STRING; n_phase = umjp_pkg::PH_ERR;
                    end else begin
                        for (int k = 0; k < 8; k++)
                            if (r_key_pos >= {1'b0, umjp_pkg::key_len(3'(k))} ||
                                umjp_pkg::key_char(3'(k), r_key_pos[3:0]) != c)
                                n_key_match[k] = 1'b0;
                        n_key_pos = r_key_pos + 5'd1;
                    end
                end
                umjp_pkg::PH_COLON: begin
                    if (c == ":") begin
                        if (r_key_match == 8'd0) begin
                            n_err = umjp_pkg::ST_UNKNOWN; n_phase = umjp_pkg::PH_ERR;
                        end else if ((r_seen & r_key_match) != 8'd0) begin
                            n_err = umjp_pkg::ST_DUP; n_phase = umjp_pkg::PH_ERR;
                        end else begin
                            n_seen = r_seen | r_key_match;
                            if (fid == 3'd1 || fid == 3'd2) n_phase = umjp_pkg::PH_STR_START;
                            else if (fid >= 3'd6) n_phase = umjp_pkg::PH_HEX_START;
                            else n_phase = umjp_pkg::PH_NUM_START;
                        end
                    end else if (!umjp_pkg::is_space(c)) begin
                        n_err = umjp_pkg::ST_SYNTAX; n_phase = umjp_pkg::PH_ERR;
                    end
                end
                umjp_pkg::PH_NUM_START: begin
                    if (is_dig) begin
                        n_acc = {28'd0, dig}; n_lz = (c == "0");
                        n_phase = umjp_pkg::PH_NUM;
                    end else if (!umjp_pkg::is_space(c)) begin
                        n_err = umjp_pkg::ST_NUMBER; n_phase = umjp_pkg::PH_ERR;
                    end
                end
                umjp_pkg::PH_NUM: begin
                    if (is_dig) begin
                        if (r_lz || acc10[35:32] != 4'd0) begin
                            n_err = umjp_pkg::ST_NUMBER; n_phase = umjp_pkg::PH_ERR;
                        end else n_acc = acc10[31:0];
                    end else if (fid == umjp_pkg::FID_SCHEMA && r_acc[31:16] != 16'd0) begin
                        n_err = umjp_pkg::ST_NUMBER; n_phase = umjp_pkg::PH_ERR;
                    end else begin
                        if (fid == umjp_pkg::FID_SCHEMA) n_schema = r_acc[15:0];
                        else if (fid == umjp_pkg::FID_BUILD) n_build = r_acc;
                        else if (fid == umjp_pkg::FID_BUILD_FLOOR) n_minb = r_acc;
                        else n_size = r_acc;
                        res0.kind = umjp_pkg::KIND_NUMBER; res0.field_id = fid;
                        res0.value = r_acc; push_cnt = 2'd1;
                        n_fcnt = r_fcnt + 4'd1;
                        n_phase = umjp_pkg::PH_AFTER;
                        if (!umjp_pkg::is_space(c)) begin
                            if (r_fcnt < 4'd7 && c == ",") n_phase = umjp_pkg::PH_KEY_START;
                            else if (r_fcnt >= 4'd7 && c == "}") n_phase = umjp_pkg::PH_DONE;
                            else begin
                                n_err = umjp_pkg::ST_SYNTAX; n_phase = umjp_pkg::PH_ERR;
                            end
                        end
                    end
                end
                umjp_pkg::PH_STR_START, umjp_pkg::PH_HEX_START: begin
                    if (c == "\"") begin
                        n_phase = (r_phase == umjp_pkg::PH_STR_START) ? umjp_pkg::PH_STR
                                                                      : umjp_pkg::PH_HEX;
                        n_slen = '0; n_hn = '0;
                    end else if (!umjp_pkg::is_space(c)) begin
                        n_err = umjp_pkg::ST_STRING; n_phase = umjp_pkg::PH_ERR;
                    end
                end
                umjp_pkg::PH_STR: begin
                    if (c == "\"") begin
                        if (r_slen == 8'd0) begin
                            n_err = umjp_pkg::ST_STRING; n_phase = umjp_pkg::PH_ERR;
                        end else begin
                            n_fcnt = r_fcnt + 4'd1; n_phase = umjp_pkg::PH_AFTER;
                        end
                    end else if (c < 8'h20 || c == "\\" || r_slen >= TEXT_MAX) begin
                        n_err = umjp_pkg::ST_STRING; n_phase = umjp_pkg::PH_ERR;
                    end else begin
                        res0.kind = umjp_pkg::KIND_BYTE; res0.field_id = fid;
                        res0.value = {24'd0, c}; res0.byte_index = r_slen[5:0];
                        push_cnt = 2'd1; n_slen = r_slen + 8'd1;
                    end
                end
                umjp_pkg::PH_HEX: begin
                    if (c == "\"") begin
                        if (r_slen != digits) begin
                            n_err = umjp_pkg::ST_HEX; n_phase = umjp_pkg::PH_ERR;
                        end else begin
                            n_fcnt = r_fcnt + 4'd1; n_phase = umjp_pkg::PH_AFTER;
                        end
                    end else if (c < 8'h20 || c == "\\") begin
                        n_err = umjp_pkg::ST_STRING; n_phase = umjp_pkg::PH_ERR;
                    end else if (!is_hex || r_slen >= digits) begin
                        n_err = umjp_pkg::ST_HEX; n_phase = umjp_pkg::PH_ERR;
                    end else begin
                        if (!r_hn[4]) n_hn = {1'b1, hv};
                        else begin
                            res0.kind = umjp_pkg::KIND_BYTE; res0.field_id = fid;
                            res0.value = {24'd0, r_hn[3:0], hv};
                            res0.byte_index = r_slen[6:1];
                            push_cnt = 2'd1; n_hn = '0;
                        end
                        n_slen = r_slen + 8'd1;
                    end
                end
                umjp_pkg::PH_AFTER: begin
                    if (!umjp_pkg::is_space(c)) begin
                        if (r_fcnt < 4'd8 && c == ",") n_phase = umjp_pkg::PH_KEY_START;
                        else if (r_fcnt >= 4'd8 && c == "}") n_phase = umjp_pkg::PH_DONE;
                        else begin
                            n_err = umjp_pkg::ST_SYNTAX; n_phase = umjp_pkg::PH_ERR;
                        end
                    end
                end
                umjp_pkg::PH_DONE: begin
                    if (!umjp_pkg::is_space(c)) begin
                        n_err = umjp_pkg::ST_SYNTAX; n_phase = umjp_pkg::PH_ERR;
                    end
                end
                default: ;
            endcase
            // length error overrides a parse error of this same byte
            if (r_bcnt >= r_max_text) begin
                n_err = umjp_pkg::ST_LENGTH; n_phase = umjp_pkg::PH_ERR;
            end
            // a byte that is over length or taken in the error phase emits nothing
            if (r_phase == umjp_pkg::PH_ERR || r_bcnt >= r_max_text) push_cnt = 2'd0;

            if (i_in.end_of_text) begin
                if (n_err != 4'd0) st = n_err;
                else if (n_phase != umjp_pkg::PH_DONE) st = umjp_pkg::ST_SYNTAX;
                else if (n_schema != 16'd1 || n_build <= n_minb || n_size == 32'd0 ||
                         n_size > r_max_image) st = umjp_pkg::ST_SEMANTIC;
                else st = umjp_pkg::ST_OK;
                res1.kind = umjp_pkg::KIND_VERDICT; res1.status = st; res1.last = 1'b1;
                if (push_cnt == 2'd0) begin
                    res0 = res1; push_cnt = 2'd1;
                end else push_cnt = 2'd2;
                n_phase = umjp_pkg::PH_OPEN; n_key_match = 8'hFF; n_key_pos = '0;
                n_seen = '0; n_fcnt = '0; n_acc = '0; n_lz = 1'b0; n_slen = '0;
                n_hn = '0; n_schema = '0; n_build = '0; n_minb = '0; n_size = '0;
                n_err = '0; n_bcnt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= umjp_pkg::PH_OPEN; r_key_match <= 8'hFF; r_key_pos <= '0;
            r_seen <= '0; r_fcnt <= '0; r_acc <= '0; r_lz <= 1'b0; r_slen <= '0;
            r_hn <= '0; r_schema <= '0; r_build <= '0; r_minb <= '0; r_size <= '0;
            r_err <= '0; r_bcnt <= '0;
        end else begin
            r_phase <= n_phase; r_key_match <= n_key_match; r_key_pos <= n_key_pos;
            r_seen <= n_seen; r_fcnt <= n_fcnt; r_acc <= n_acc; r_lz <= n_lz;
            r_slen <= n_slen; r_hn <= n_hn; r_schema <= n_schema; r_build <= n_build;
            r_minb <= n_minb; r_size <= n_size; r_err <= n_err; r_bcnt <= n_bcnt;
        end
    end

    umjp_out_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_push0    (res0),
        .i_push1    (res1),
        .o_room     (room),
        .o_out      (o_out)
    );

`ifndef NO_ASSERTIONS
    a_err_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != 4'd0) |-> r_phase == umjp_pkg::PH_ERR) else $error("error without ERR");
    a_no_emit_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_phase == umjp_pkg::PH_ERR && !i_in.end_of_text) |-> push_cnt == 2'd0)
        else $error("emit after error");
    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_in.end_of_text) |=> r_bcnt == 16'd0 && r_phase == umjp_pkg::PH_OPEN)
        else $error("verdict did not clear");
`endif
endmodule

@@ tb/umjp_checker.sv @@
module umjp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    umjp_in_if          in_ch,
    umjp_out_if         out_ch,
    output int          o_errors,
    output int          o_pending,
    output int          o_verdicts,
    output int          o_clean
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_MAX  = 15;
    localparam int TEXT_MAX = 15;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    string key_txt [8] = '{"schema", "product", "version", "build",
                           {"min_", "build"}, "size", "sha256", "signature"};

    // register shadows
    logic [15:0] max_text;
    logic [31:0] max_image;

    // parser shadow state
    umjp_pkg::t_phase  ph;
    logic [7:0]  kmatch;
    int          kpos;
    logic [7:0]  seen;
    int          nfields;
    logic [31:0] acc;
    bit          lz;
    int          slen;
    logic [4:0]  nib;
    logic [31:0] schema_v, build_v, minb_v, size_v;
    umjp_pkg::t_status err;
    logic [15:0] nbytes;

    umjp_pkg::t_result pending_results[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        o_errors++;
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    endtask

    task automatic clear_manifest();
        ph = umjp_pkg::PH_OPEN; kmatch = 8'hFF; kpos = 0; seen = 8'h00; nfields = 0;
        acc = 0; lz = 0; slen = 0; nib = 0; schema_v = 0; build_v = 0;
        minb_v = 0; size_v = 0; err = umjp_pkg::ST_OK; nbytes = 0;
    endtask

    function automatic bit is_ws(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic logic [2:0] cur_field();
        for (int k = 0; k < 8; k++)
            if (kmatch[k]) return k[2:0];
        return 3'd0;
    endfunction

    task automatic fail_with(input umjp_pkg::t_status s);
        err = s;
        ph = umjp_pkg::PH_ERR;
    endtask

    task automatic push_result(input logic [1:0] kind, input logic [2:0] fid,
                               input logic [31:0] value, input int idx,
                               input umjp_pkg::t_status s, input logic last);
        umjp_pkg::t_result r;
        r.kind = kind; r.field_id = fid; r.value = value;
        r.byte_index = idx[5:0]; r.status = s; r.last = last;
        pending_results.push_back(r);
    endtask

    // delimiter after a completed value
    task automatic close_value(input logic [7:0] c);
        if (is_ws(c)) return;
        if (nfields < 8 && c == CH_COMMA) ph = umjp_pkg::PH_KEY_START;
        else if (nfields >= 8 && c == CH_RBRACE) ph = umjp_pkg::PH_DONE;
        else fail_with(umjp_pkg::ST_SYNTAX);
    endtask

    // key resolved at the colon
    task automatic key_done();
        logic [2:0] f;
        if (kmatch == 0) begin
            fail_with(umjp_pkg::ST_UNKNOWN);
            return;
        end
        if ((seen & kmatch) != 0) begin
            fail_with(umjp_pkg::ST_DUP);
            return;
        end
        seen |= kmatch;
        f = cur_field();
        if (f == 3'd1 || f == 3'd2) ph = umjp_pkg::PH_STR_START;
        else if (f >= 3'd6) ph = umjp_pkg::PH_HEX_START;
        else ph = umjp_pkg::PH_NUM_START;
    endtask

    task automatic parse_char(input logic [7:0] c);
        logic [2:0] f;
        int         digits;
        int         h;
        longint     d;
        f = cur_field();
        case (ph)
            umjp_pkg::PH_OPEN: begin
                if (c == CH_LBRACE) ph = umjp_pkg::PH_KEY_START;
                else if (!is_ws(c)) fail_with(umjp_pkg::ST_SYNTAX);
            end
            umjp_pkg::PH_KEY_START: begin
                if (c == CH_QUOTE) begin
                    ph = umjp_pkg::PH_KEY; kmatch = 8'hFF; kpos = 0;
                end else if (!is_ws(c)) fail_with(umjp_pkg::ST_SYNTAX);
            end
            umjp_pkg::PH_KEY: begin
                if (c == CH_QUOTE) begin
                    for (int k = 0; k < 8; k++)
                        if (key_txt[k].len() != kpos) kmatch[k] = 1'b0;
                    ph = umjp_pkg::PH_COLON;
                end else if (c < 8'h20 || c == CH_BSLASH || kpos >= KEY_MAX) begin
                    fail_with(umjp_pkg::ST_STRING);
                end else begin
                    for (int k = 0; k < 8; k++)
                        if (kpos >= key_txt[k].len() || key_txt[k][kpos] != c)
                            kmatch[k] = 1'b0;
                    kpos++;
                end
            end
            umjp_pkg::PH_COLON: begin
                if (c == CH_COLON) key_done();
                else if (!is_ws(c)) fail_with(umjp_pkg::ST_SYNTAX);
            end
            umjp_pkg::PH_NUM_START: begin
                if (c >= "0" && c <= "9") begin
                    acc = 32'(c - "0"); lz = (c == "0"); ph = umjp_pkg::PH_NUM;
                end else if (!is_ws(c)) fail_with(umjp_pkg::ST_NUMBER);
            end
            umjp_pkg::PH_NUM: begin
                if (c >= "0" && c <= "9") begin
                    d = longint'(c - "0");
                    if (lz || longint'(acc) * 10 + d > 64'hFFFF_FFFF)
                        fail_with(umjp_pkg::ST_NUMBER);
                    else acc = 32'(longint'(acc) * 10 + d);
                end else if (f == 3'd0 && acc > 32'hFFFF) begin
                    fail_with(umjp_pkg::ST_NUMBER);
                end else begin
                    if (f == 3'd0) schema_v = acc;
                    else if (f == 3'd3) build_v = acc;
                    else if (f == 3'd4) minb_v = acc;
                    else size_v = acc;
                    push_result(umjp_pkg::KIND_NUMBER, f, acc, 0, umjp_pkg::ST_OK, 1'b0);
                    nfields++;
                    ph = umjp_pkg::PH_AFTER;
                    close_value(c);
                end
            end
            umjp_pkg::PH_STR_START, umjp_pkg::PH_HEX_START: begin
                if (c == CH_QUOTE) begin
                    ph = (ph == umjp_pkg::PH_STR_START) ? umjp_pkg::PH_STR : umjp_pkg::PH_HEX;
                    slen = 0; nib = 0;
                end else if (!is_ws(c)) fail_with(umjp_pkg::ST_STRING);
            end
            umjp_pkg::PH_STR: begin
                if (c == CH_QUOTE) begin
                    if (slen == 0) fail_with(umjp_pkg::ST_STRING);
                    else begin
                        nfields++; ph = umjp_pkg::PH_AFTER;
                    end
                end else if (c < 8'h20 || c == CH_BSLASH || slen >= TEXT_MAX) begin
                    fail_with(umjp_pkg::ST_STRING);
                end else begin
                    push_result(umjp_pkg::KIND_BYTE, f, {24'd0, c}, slen, umjp_pkg::ST_OK,
                                1'b0);
                    slen++;
                end
            end
            umjp_pkg::PH_HEX: begin
                digits = (f == 3'd6) ? 64 : 128;
                h = hex_digit(c);
                if (c == CH_QUOTE) begin
                    if (slen != digits) fail_with(umjp_pkg::ST_HEX);
                    else begin
                        nfields++; ph = umjp_pkg::PH_AFTER;
                    end
                end else if (c < 8'h20 || c == CH_BSLASH) begin
                    fail_with(umjp_pkg::ST_STRING);
                end else if (h < 0 || slen >= digits) begin
                    fail_with(umjp_pkg::ST_HEX);
                end else begin
                    if (!nib[4]) begin
                        nib = {1'b1, h[3:0]};
                    end else begin
                        push_result(umjp_pkg::KIND_BYTE, f, {24'd0, nib[3:0], h[3:0]},
                                    slen >> 1, umjp_pkg::ST_OK, 1'b0);
                        nib = 0;
                    end
                    slen++;
                end
            end
            umjp_pkg::PH_AFTER: close_value(c);
            umjp_pkg::PH_DONE: if (!is_ws(c)) fail_with(umjp_pkg::ST_SYNTAX);
            default: ;
        endcase
    endtask

    // one accepted byte: length check, parse, verdict on the last byte
    task automatic manifest_byte(input logic [7:0] c, input logic eot);
        umjp_pkg::t_status v;
        if (nbytes >= max_text) fail_with(umjp_pkg::ST_LENGTH);
        else nbytes++;
        if (ph != umjp_pkg::PH_ERR) parse_char(c);
        if (eot) begin
            if (err != umjp_pkg::ST_OK) v = err;
            else if (ph != umjp_pkg::PH_DONE) v = umjp_pkg::ST_SYNTAX;
            else if (schema_v != 1 || build_v <= minb_v || size_v == 0 ||
                     size_v > max_image) v = umjp_pkg::ST_SEMANTIC;
            else v = umjp_pkg::ST_OK;
            push_result(umjp_pkg::KIND_VERDICT, 3'd0, 32'd0, 0, v, 1'b1);
            clear_manifest();
        end
    endtask

    initial begin
        o_errors = 0; o_pending = 0; o_verdicts = 0; o_clean = 0;
        max_text = 16'd1024; max_image = 32'hB0_0000;
        clear_manifest();
    end

    always @(posedge i_clk) begin
        umjp_pkg::t_result want;
        if (!i_rst_n) begin
            max_text = 16'd1024;
            max_image = 32'hB0_0000;
            clear_manifest();
            pending_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == 1'(umjp_pkg::CFG_MAX_TEXT)) max_text = i_cfg_data[15:0];
                else max_image = i_cfg_data;
            end
            // result transfer: compare with the oldest expectation
            if (out_ch.valid && out_ch.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", out_ch.value, 32'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (out_ch.kind != want.kind)
                        report_mismatch("kind", 32'(out_ch.kind), 32'(want.kind));
                    if (out_ch.field_id != want.field_id)
                        report_mismatch("field_id", 32'(out_ch.field_id),
                                        32'(want.field_id));
                    if (out_ch.value != want.value)
                        report_mismatch("value", out_ch.value, want.value);
                    if (out_ch.byte_index != want.byte_index)
                        report_mismatch("byte_index", 32'(out_ch.byte_index),
                                        32'(want.byte_index));
                    if (out_ch.status != want.status)
                        report_mismatch("status", 32'(out_ch.status), 32'(want.status));
                    if (out_ch.last != want.last)
                        report_mismatch("last", 32'(out_ch.last), 32'(want.last));
                    if (want.kind == umjp_pkg::KIND_VERDICT) begin
                        o_verdicts++;
                        if (want.status == umjp_pkg::ST_OK) o_clean++;
                    end
                end
            end
            // byte transfer: predict its results
            if (in_ch.valid && in_ch.ready)
                manifest_byte(in_ch.data_byte, in_ch.end_of_text);
        end
        o_pending = pending_results.size();
    end
endmodule

@@ tb/tb_update_manifest_json_parser_unit.sv @@
module tb_update_manifest_json_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;

    // error flavors a generated manifest may carry
    typedef enum int {
        BAD_NONE, BAD_UNKNOWN_KEY, BAD_DUP_KEY, BAD_MISSING, BAD_LEAD_ZERO, BAD_OVERFLOW,
        BAD_SCHEMA, BAD_STR_CHAR, BAD_STR_LEN, BAD_HEX_CHAR, BAD_HEX_LEN, BAD_CORRUPT,
        BAD_TAIL, BAD_PUNCT
    } t_flaw;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    umjp_in_if  in_ch ();
    umjp_out_if out_ch ();

    int errors, pending, verdicts, clean;
    int idle_in, idle_out;
    int hold_left;
    bit hold_req;
    int quiet;
    int bytes_sent, manifests;
    logic [31:0] cur_image;
    logic [7:0] txt[$];

    string key_txt [8] = '{"schema", "product", "version", "build",
                           {"min_", "build"}, "size", "sha256", "signature"};
    string hex_set = "0123456789abcdefABCDEF";

    update_manifest_json_parser_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    umjp_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_verdicts  (verdicts),
        .o_clean     (clean)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= idle_out);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
        else quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("Timeout after %0d quiet cycles", quiet);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        if ($urandom_range(0, 99) < idle_in) begin
            in_ch.valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < idle_in);
        end
        in_ch.valid       <= 1'b1;
        in_ch.data_byte   <= b;
        in_ch.end_of_text <= eot;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    // stop offering and wait until every expected result has come
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_regs(input logic [15:0] text_max, input logic [31:0] image_max);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= 1'(umjp_pkg::CFG_MAX_TEXT);
        i_cfg_data  <= {16'd0, text_max};
        @(negedge i_clk);
        i_cfg_index <= 1'(umjp_pkg::CFG_MAX_IMAGE);
        i_cfg_data  <= image_max;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_image = image_max;
    endtask

    task automatic put(input string s);
        for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    endtask

    task automatic put_ws();
        int n;
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n) begin
            case ($urandom_range(0, 3))
                0: txt.push_back(8'h20);
                1: txt.push_back(8'h09);
                2: txt.push_back(8'h0D);
                default: txt.push_back(8'h0A);
            endcase
        end
    endtask

    task automatic put_number(input int f, input t_flaw flaw);
        longint v;
        case (f)
            0: case ($urandom_range(0, 9))
                0: v = 0;
                1: v = 65535;
                2: v = 65536;
                3: v = longint'($urandom_range(2, 9));
                default: v = 1;
            endcase
            3: v = ($urandom_range(0, 4) == 0) ? longint'($urandom_range(0, 999))
                                               : longint'($urandom);
            4: v = ($urandom_range(0, 9) == 0) ? longint'($urandom)
                                               : longint'($urandom_range(0, 99999));
            default: case ($urandom_range(0, 5))
                0: v = 0;
                1: v = 1;
                2: v = longint'(cur_image);
                3: v = longint'(cur_image) + 1;
                4: v = 64'hFFFF_FFFF;
                default: v = longint'($urandom_range(1, 24'hFF_FFFF));
            endcase
        endcase
        if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
        if (flaw == BAD_LEAD_ZERO) put("0");
        if (flaw == BAD_OVERFLOW) put($urandom_range(0, 1) ? "4294967296" : "99999999999");
        else if (flaw == BAD_SCHEMA && f == 0) put($sformatf("%0d", $urandom_range(65536, 99999)));
        else put($sformatf("%0d", v));
    endtask

    task automatic put_text(input t_flaw flaw);
        int n;
        int bad;
        logic [7:0] c;
        n = $urandom_range(1, 15);
        if (flaw == BAD_STR_LEN) n = $urandom_range(0, 1) ? 0 : 16;
        bad = (flaw == BAD_STR_CHAR) ? $urandom_range(0, n) : -1;
        put("\"");
        for (int i = 0; i < n; i++) begin
            c = 8'($urandom_range(32, 126));
            if (c == 8'h22 || c == 8'h5C) c = "a";
            if (i == bad) c = $urandom_range(0, 1) ? 8'h5C : 8'($urandom_range(0, 31));
            txt.push_back(c);
        end
        put("\"");
    endtask

    task automatic put_hex(input int f, input t_flaw flaw);
        int n;
        int bad;
        n = (f == 6) ? 64 : 128;
        if (flaw == BAD_HEX_LEN) n = n + ($urandom_range(0, 1) ? 1 : -2);
        bad = (flaw == BAD_HEX_CHAR) ? $urandom_range(0, n - 1) : -1;
        put("\"");
        for (int i = 0; i < n; i++) begin
            if (i == bad) txt.push_back($urandom_range(0, 1) ? "g" : 8'h01);
            else txt.push_back(hex_set[$urandom_range(0, 21)]);
        end
        put("\"");
    endtask

    // one manifest: nearly half well formed, most others with one flaw, a few pure noise
    task automatic build_manifest();
        int order[8];
        int nf, j, t, pick;
        t_flaw flaw;
        txt.delete();
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 20)) txt.push_back(8'($urandom_range(0, 255)));
            return;
        end
        flaw = ($urandom_range(0, 99) < 50) ? BAD_NONE : t_flaw'($urandom_range(1, 13));
        for (int i = 0; i < 8; i++) order[i] = i;
        for (int i = 7; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i]; order[i] = order[j]; order[j] = t;
        end
        nf = 8;
        if (flaw == BAD_DUP_KEY) order[$urandom_range(1, 7)] = order[0];
        if (flaw == BAD_MISSING) nf = 7;
        pick = $urandom_range(0, nf - 1);
        put_ws();
        put("{");
        for (int i = 0; i < nf; i++) begin
            put_ws();
            put("\"");
            if (flaw == BAD_UNKNOWN_KEY && i == pick)
                put($urandom_range(0, 1) ? "sizes" : "Build");
            else put(key_txt[order[i]]);
            put("\"");
            put_ws();
            if (!(flaw == BAD_PUNCT && i == pick)) put(":");
            put_ws();
            case (order[i])
                1, 2: put_text(flaw);
                6, 7: put_hex(order[i], flaw);
                default: put_number(order[i], flaw);
            endcase
            put_ws();
            if (i < nf - 1) put(",");
        end
        put_ws();
        put("}");
        put_ws();
        if (flaw == BAD_TAIL) begin
            if ($urandom_range(0, 1)) put("x");
            else txt = txt[0:$urandom_range(0, txt.size() - 1)];
        end
        if (flaw == BAD_CORRUPT)
            txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
    endtask

    // send the built text, marking its final byte
    task automatic send_manifest();
        for (int i = 0; i < txt.size(); i++) send_byte(txt[i], i == txt.size() - 1);
        manifests++;
    endtask

    // whole manifests until the next one would pass the byte budget
    task automatic run_manifests(input int byte_goal);
        int start;
        start = bytes_sent;
        forever begin
            build_manifest();
            if (bytes_sent != start && bytes_sent - start + txt.size() > byte_goal) break;
            send_manifest();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.end_of_text = 1'b0;
        out_ch.ready = 1'b0;
        hold_req = 1'b0;
        quiet = 0;
        bytes_sent = 0;
        manifests = 0;
        idle_in = 0;
        idle_out = 0;
        cur_image = 32'hB0_0000;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: byte extremes, empty object, bad openers, a lone field and a leading zero
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte("{", 1'b0);
        send_byte("}", 1'b1);
        send_byte(8'h20, 1'b0);
        send_byte("[", 1'b1);
        txt.delete();
        put("{\"size\":0}");
        for (int i = 0; i < txt.size(); i++) send_byte(txt[i], i == txt.size() - 1);
        txt.delete();
        put("{\"schema\":01");
        for (int i = 0; i < txt.size(); i++) send_byte(txt[i], i == txt.size() - 1);
        drain();

        // default limits, sender idles less than receiver
        write_regs(16'd1024, 32'hB0_0000);
        idle_in = 30; idle_out = 73;
        run_manifests(300);
        drain();

        // widest limits, roles swapped
        write_regs(16'hFFFF, 32'hFFFF_FFFF);
        idle_in = 73; idle_out = 30;
        run_manifests(300);
        drain();

        // smallest limits: length and size checks trip at once
        write_regs(16'd1, 32'd1);
        idle_in = 0; idle_out = 0;
        run_manifests(100);
        drain();

        // mid limits, no idling, receiver held off while bytes keep coming
        write_regs(16'($urandom_range(300, 500)), $urandom_range(1, 32'h00FF_FFFF));
        hold_req = 1'b1;
        run_manifests(300);
        drain();

        $display("Sent %0d bytes in %0d manifests under four limit settings;", bytes_sent,
                 manifests);
        $display("%0d verdicts checked, %0d of them clean", verdicts, clean);
        if (errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
